// ===== rtl/rse_pkg.sv =====
`timescale 1ns / 1ps

package rse_pkg;

   localparam int DATA_W              = 32;
   localparam int CODE_W              = 2;
   localparam int STATUS_W            = 2;
   localparam int TDATA_W             = 40;
   localparam int DEFAULT_STACK_DEPTH = 16;

   typedef enum logic [0:0] {
      TOK_VALUE = 1'b0,
      TOK_OPER  = 1'b1
   } token_kind_type;

   typedef enum logic [CODE_W-1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2
   } op_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   // per-cell update command, one of them at most is set
   typedef struct packed {
      logic load;   // take the value from the load input
      logic push;   // take the value of the neighbor above
      logic pop;    // take the value of the neighbor below
   } cell_ctrl_type;

endpackage

// ===== rtl/rse_cell.sv =====
`timescale 1ns / 1ps

module rse_cell (
   input  logic                         clock,
   input  rse_pkg::cell_ctrl_type       ctrl,
   input  logic [rse_pkg::DATA_W-1:0]   load_data,
   input  logic [rse_pkg::DATA_W-1:0]   up_data,
   input  logic [rse_pkg::DATA_W-1:0]   down_data,
   output logic [rse_pkg::DATA_W-1:0]   data
);
   import rse_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.push) begin
         data_in = up_data;
      end else if (ctrl.pop) begin
         data_in = down_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/rse_alu.sv =====
`timescale 1ns / 1ps

module rse_alu (
   input  logic [rse_pkg::DATA_W-1:0]   first_op,
   input  logic [rse_pkg::DATA_W-1:0]   second_op,
   input  logic [rse_pkg::CODE_W-1:0]   code,
   output logic [rse_pkg::DATA_W-1:0]   result
);
   import rse_pkg::*;

   // wrapping 32-bit arithmetic, low half of the product
   always_comb begin
      case (code)
         OP_ADD:  result = first_op + second_op;
         OP_SUB:  result = first_op - second_op;
         OP_MUL:  result = first_op * second_op;
         default: result = '0;
      endcase
   end

endmodule

// ===== rtl/rpn_stack_evaluator_unit.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake             tdata (low bit up)                      tuser / tlast
// req_     in   req_tvalid/tready     operand_value[31:0] operator_code[33:32] req_type / end
// rsp_     out  rsp_tvalid/tready     final_value[31:0] status[33:32]         -
//
// one request per clock unless stalled: cells shift, the alu adds, subtracts or multiplies
// and the top cell loads, all in the same cycle; the multiplier sets the critical path
// a result appears in the output register in the cycle after the last token is taken
// synchronous reset empties the stack and clears the error; cells are not reset
// a pending result that is not taken stalls req_tready until rsp_tready

module rpn_stack_evaluator_unit #(
   parameter int STACK_DEPTH = rse_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rse_pkg::TDATA_W-1:0]   req_tdata,   // operand_value, operator_code, pad
   input  logic                          req_tuser,   // req_type
   input  logic                          req_tlast,   // end_of_expression
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rse_pkg::TDATA_W-1:0]   rsp_tdata    // final_value, status, pad
);
   import rse_pkg::*;

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

   // stack occupancy and sticky error
   logic [DEPTH_W-1:0]   depth_ff;
   logic [DEPTH_W-1:0]   depth_in;
   logic [STATUS_W-1:0]  err_ff;
   logic [STATUS_W-1:0]  err_in;

   // output register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [TDATA_W-1:0]   rsp_data_ff;
   logic [TDATA_W-1:0]   rsp_data_in;

   logic                 accept;
   logic [DATA_W-1:0]    in_value;
   logic [CODE_W-1:0]    in_code;
   logic                 is_oper;

   logic                 do_push;
   logic                 do_oper;
   logic [DATA_W-1:0]    alu_result;
   logic [DATA_W-1:0]    top_next;
   logic [STATUS_W-1:0]  final_status;
   logic [DATA_W-1:0]    final_value;

   // cell row, index 0 is top of stack
   logic [DATA_W-1:0]    cell_data [STACK_DEPTH];
   cell_ctrl_type        cell_ctrl [STACK_DEPTH];

   assign in_value = req_tdata[DATA_W-1:0];
   assign in_code  = req_tdata[DATA_W +: CODE_W];
   assign is_oper  = (req_tuser == TOK_OPER);

   // free slot in the output register or it drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // legal stack moves, ignored once an error is held
   assign do_push = accept && (err_ff == ST_OK) && !is_oper
                    && (depth_ff != DEPTH_W'(STACK_DEPTH));
   assign do_oper = accept && (err_ff == ST_OK) && is_oper
                    && (depth_ff >= DEPTH_W'(2));

   rse_alu u_alu (
      .first_op  (cell_data[1]),
      .second_op (cell_data[0]),
      .code      (in_code),
      .result    (alu_result)
   );

   // top cell loads either the pushed value or the operator result,
   // the rest shift down on push and up on operator
   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         cell_ctrl[i] = '0;
         if (i == 0) begin
            cell_ctrl[i].load = do_push || do_oper;
         end else begin
            cell_ctrl[i].push = do_push;
            cell_ctrl[i].pop  = do_oper;
         end
      end
   end

   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      if (g == STACK_DEPTH - 1) begin : g_bottom
         rse_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[g]),
            .load_data (do_push ? in_value : alu_result),
            .up_data   (cell_data[g-1]),
            .down_data (cell_data[g]),
            .data      (cell_data[g])
         );
      end else if (g == 0) begin : g_top
         rse_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[g]),
            .load_data (do_push ? in_value : alu_result),
            .up_data   (in_value),
            .down_data (cell_data[g+1]),
            .data      (cell_data[g])
         );
      end else begin : g_mid
         rse_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[g]),
            .load_data (do_push ? in_value : alu_result),
            .up_data   (cell_data[g-1]),
            .down_data (cell_data[g+1]),
            .data      (cell_data[g])
         );
      end
   end

   // occupancy, error and the report for a last token
   always_comb begin
      depth_in = depth_ff;
      err_in   = err_ff;
      top_next = cell_data[0];
      if (do_push) begin
         depth_in = depth_ff + DEPTH_W'(1);
         top_next = in_value;
      end else if (do_oper) begin
         depth_in = depth_ff - DEPTH_W'(1);
         top_next = alu_result;
      end else if (accept && (err_ff == ST_OK)) begin
         // push on a full stack or operator short of operands
         err_in = is_oper ? ST_UNDERFLOW : ST_OVERFLOW;
      end

      // empty stack at the end reports underflow
      final_status = err_in;
      if ((err_in == ST_OK) && (depth_in == '0)) begin
         final_status = ST_UNDERFLOW;
      end
      final_value = (final_status == ST_OK) ? top_next : '0;

      if (accept && req_tlast) begin
         depth_in = '0;
         err_in   = ST_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(TDATA_W - DATA_W - STATUS_W){1'b0}}, final_status, final_value};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // occupancy never passes the number of cells
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("stack occupancy beyond cell count");

   // a reported expression leaves an empty stack and no error
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> (depth_ff == '0) && (err_ff == ST_OK))
      else $error("state not cleared after last token");

   // a new result appears only after a last token was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && req_tlast))
      else $error("result without a last token");

   // an error report carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[DATA_W +: STATUS_W] != ST_OK)
      |-> (rsp_data_ff[DATA_W-1:0] == '0))
      else $error("nonzero value with error status");

endmodule
